@@ src/scan_based_speed_limiter_macros.svh @@
// Assertion macros for the speed limiter.
// Included by modules that check their own control logic; no other dependencies.
`ifndef SCAN_BASED_SPEED_LIMITER_MACROS_SVH
`define SCAN_BASED_SPEED_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLIM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/slim_pkg.sv @@
// Shared types and constants for the scan based speed limiter.
// No dependencies; used by every module of the block.
package slim_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SAFE_TIME = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_MAX_RANGE = 2'd2;
  localparam logic [1:0] REG_SCAN_LEN  = 2'd3;

  localparam logic [15:0] RST_SAFE_TIME = 16'd5000;
  localparam logic [15:0] RST_RADIUS    = 16'd200;
  localparam logic [15:0] RST_MAX_RANGE = 16'd30000;
  localparam logic [11:0] RST_SCAN_LEN  = 12'd360;

  // clearance "none seen" marker and full-scale speed
  localparam logic [16:0] NONE_CLR   = 17'h1FFFF;
  localparam logic [14:0] FULL_SCALE = 15'h7FFF;
  // mm per ms -> mm per s
  localparam int unsigned CLR_TO_SPEED = 1000;

  // divider sizes: clr*1000 < 2^26, |ang|*lim < 2^30
  localparam int unsigned DIVD_W = 30;
  localparam int unsigned DIVS_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] safe_time;
    logic [15:0] radius;
    logic [15:0] max_range;
    logic [11:0] scan_len;
  } cfg_t;

  // one classified beat on its way to the back end
  typedef struct packed {
    logic               is_cmd;
    logic               last;
    logic               is_front;
    logic               valid;
    logic [15:0]        clr;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
  } entry_t;

endpackage

@@ src/scan_based_speed_limiter.sv @@
// Scan based speed limiter: top level with configuration registers.
// Uses slim_pkg, slim_front, slim_fifo and slim_back.
//
// Input stream (in_*): each beat is a range sample (in_tuser = 0) or a velocity
// command (in_tuser = 1). in_tlast on a sample closes the scan and commits the
// front and back speed limits. Samples give no output; every command gives one
// output beat with the limited speeds and the was_limited flag.
// Config port: cfg_we writes cfg_wdata to register cfg_addr (0 safe time ms,
// 1 robot radius mm, 2 max valid range mm, 3 scan length); write only while idle.
// Timing: a beat enters a 2-entry queue the cycle it is accepted. A valid sample
// updates its half's minimum clearance as it leaves the queue; a command within
// its limit goes from the queue into the output register. Limited commands and
// committing samples use the 30-step restoring divider shared by limits and ratios.
// Reset (rst_n low, synchronous): registers to defaults, limits unlimited,
// queue and output empty. When out_tready is low the result waits in the output
// register; samples still flow, and in_tready drops once the queue fills.
module scan_based_speed_limiter #(
  parameter int unsigned MAX_SCAN_SAMPLES = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // range_mm[15:0], linear_mm_s[31:16], angular_mrad_s[47:32]
  input  logic        in_tlast,
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // safe_linear_mm_s[15:0], safe_angular_mrad_s[31:16]
  output logic [0:0]  out_tuser,  // was_limited[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  slim_pkg::cfg_t   cfg_r;
  slim_pkg::entry_t push_entry, head;
  logic             q_full, q_valid, push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_time <= slim_pkg::RST_SAFE_TIME;
      cfg_r.radius    <= slim_pkg::RST_RADIUS;
      cfg_r.max_range <= slim_pkg::RST_MAX_RANGE;
      cfg_r.scan_len  <= slim_pkg::RST_SCAN_LEN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        slim_pkg::REG_SAFE_TIME: cfg_r.safe_time <= cfg_wdata;
        slim_pkg::REG_RADIUS:    cfg_r.radius    <= cfg_wdata;
        slim_pkg::REG_MAX_RANGE: cfg_r.max_range <= cfg_wdata;
        slim_pkg::REG_SCAN_LEN:  cfg_r.scan_len  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  slim_front #(
    .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser[0]),
    .in_last  (in_tlast),
    .in_range (in_tdata[15:0]),
    .in_lin   (in_tdata[31:16]),
    .in_ang   (in_tdata[47:32]),
    .in_ready (in_tready),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  slim_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  slim_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ src/slim_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on slim_pkg for operand widths.
module slim_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [slim_pkg::DIVD_W-1:0]     dividend,
  input  logic [slim_pkg::DIVS_W-1:0]     divisor,
  output logic                            done,
  output logic [slim_pkg::DIVD_W-1:0]     quotient
);

  localparam int unsigned CW = $clog2(slim_pkg::DIVD_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [slim_pkg::DIVS_W-1:0]   rem_r, rem_nxt;
  logic [slim_pkg::DIVS_W-1:0]   dvs_r, dvs_nxt;
  logic [slim_pkg::DIVD_W-1:0]   quo_r, quo_nxt;
  logic [slim_pkg::DIVS_W:0]     shifted;
  logic                          ge;

  assign shifted = {rem_r, quo_r[slim_pkg::DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(slim_pkg::DIVD_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? slim_pkg::DIVS_W'(shifted - {1'b0, dvs_r})
                   : shifted[slim_pkg::DIVS_W-1:0];
      quo_nxt = {quo_r[slim_pkg::DIVD_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/slim_fifo.sv @@
// Short queue between the classifier and the execution back end.
// Depends on slim_pkg for the entry type and depth.
module slim_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  slim_pkg::entry_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output slim_pkg::entry_t head
);

  slim_pkg::entry_t                mem_r [slim_pkg::QUEUE_DEPTH];
  logic [slim_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [slim_pkg::QCNT_W-1:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign full      = count_r == slim_pkg::QCNT_W'(slim_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

endmodule

@@ src/slim_front.sv @@
// Front end: accepts input beats, tracks the scan position and classifies samples.
// Depends on slim_pkg for the config and entry types.
module slim_front #(
  parameter int unsigned MAX_SCAN_SAMPLES = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  input  slim_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  logic             in_mode,
  input  logic             in_last,
  input  logic [15:0]      in_range,
  input  logic [15:0]      in_lin,
  input  logic [15:0]      in_ang,
  output logic             in_ready,
  input  logic             q_full,
  output logic             push,
  output slim_pkg::entry_t entry
);

  localparam int unsigned CNT_W = $clog2(MAX_SCAN_SAMPLES + 1);
  localparam int unsigned CMP_W = (CNT_W > 11) ? CNT_W : 11;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SCAN_SAMPLES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [10:0]      half;

  assign half     = cfg.scan_len[11:1];
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    entry          = '0;
    entry.is_cmd   = in_mode;
    entry.last     = in_last;
    entry.is_front = CMP_W'(cnt_r) < CMP_W'(half);
    entry.valid    = in_range < cfg.max_range;
    entry.clr      = (in_range > cfg.radius) ? in_range - cfg.radius : 16'd0;
    entry.lin      = in_lin;
    entry.ang      = in_ang;
  end

  // counter saturates; a committing last sample restarts the scan
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !in_mode) begin
      if (in_last)              cnt_nxt = '0;
      else if (cnt_r < CNT_MAX) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

endmodule

@@ src/slim_back.sv @@
// Back end: keeps per-half minimum clearance, commits limits and limits commands.
// Depends on slim_pkg, slim_div and the assertion macro header.
`include "scan_based_speed_limiter_macros.svh"

module slim_back (
  input  logic                clk,
  input  logic                rst_n,
  input  slim_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  slim_pkg::entry_t    q_head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic [0:0]          out_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  localparam logic [1:0] JOB_F   = 2'd0;
  localparam logic [1:0] JOB_B   = 2'd1;
  localparam logic [1:0] JOB_CMD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  job_r, job_nxt;
  logic [16:0] front_min_r, front_min_nxt, back_min_r, back_min_nxt;
  logic [14:0] front_lim_r, front_lim_nxt, back_lim_r, back_lim_nxt;
  logic [slim_pkg::DIVD_W-1:0] prod_r, prod_nxt;
  logic [15:0] mag_r, mag_nxt, abs_ang_r, abs_ang_nxt;
  logic [14:0] lim_r, lim_nxt;
  logic        lin_neg_r, lin_neg_nxt, ang_neg_r, ang_neg_nxt;
  logic        out_valid_r, out_valid_nxt, out_limited_r, out_limited_nxt;
  logic [15:0] out_lin_r, out_lin_nxt, out_ang_r, out_ang_nxt;

  logic [15:0] lin_u, ang_u, mag_c, abs_ang_c, safe_time_eff;
  logic        lin_pos, exceed;
  logic [14:0] lim_c, sat_q;
  logic        div_start, div_done;
  logic [slim_pkg::DIVD_W-1:0] div_q;
  logic [15:0] div_divisor, q16;

  assign lin_u     = q_head.lin;
  assign ang_u     = q_head.ang;
  assign mag_c     = lin_u[15] ? (~lin_u + 16'd1) : lin_u;
  assign abs_ang_c = ang_u[15] ? (~ang_u + 16'd1) : ang_u;
  assign lin_pos   = !lin_u[15] && (lin_u != 16'd0);
  assign lim_c     = lin_pos ? front_lim_r : back_lim_r;
  assign exceed    = (lin_u != 16'd0) && (mag_c > {1'b0, lim_c});

  assign safe_time_eff = (cfg.safe_time == 16'd0) ? 16'd1 : cfg.safe_time;
  assign div_start     = state_r == ST_DIV;
  assign div_divisor   = (job_r == JOB_CMD) ? mag_r : safe_time_eff;
  assign sat_q         = (|div_q[slim_pkg::DIVD_W-1:15]) ? slim_pkg::FULL_SCALE : div_q[14:0];
  assign q16           = div_q[15:0];

  // commands wait for a free output slot so the result always has a home
  assign pop = q_valid && (state_r == ST_IDLE) &&
               (!q_head.is_cmd || !out_valid_r || out_tready);

  slim_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt       = state_r;
    job_nxt         = job_r;
    front_min_nxt   = front_min_r;
    back_min_nxt    = back_min_r;
    front_lim_nxt   = front_lim_r;
    back_lim_nxt    = back_lim_r;
    prod_nxt        = prod_r;
    mag_nxt         = mag_r;
    abs_ang_nxt     = abs_ang_r;
    lim_nxt         = lim_r;
    lin_neg_nxt     = lin_neg_r;
    ang_neg_nxt     = ang_neg_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_lin_nxt     = out_lin_r;
    out_ang_nxt     = out_ang_r;
    out_limited_nxt = out_limited_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (q_head.is_cmd) begin
            if (exceed) begin
              mag_nxt     = mag_c;
              abs_ang_nxt = abs_ang_c;
              lim_nxt     = lim_c;
              lin_neg_nxt = lin_u[15];
              ang_neg_nxt = ang_u[15];
              job_nxt     = JOB_CMD;
              state_nxt   = ST_MUL;
            end else begin
              out_valid_nxt   = 1'b1;
              out_lin_nxt     = lin_u;
              out_ang_nxt     = ang_u;
              out_limited_nxt = 1'b0;
            end
          end else begin
            if (q_head.valid) begin
              if (q_head.is_front) begin
                if ({1'b0, q_head.clr} < front_min_r) front_min_nxt = {1'b0, q_head.clr};
              end else begin
                if ({1'b0, q_head.clr} < back_min_r) back_min_nxt = {1'b0, q_head.clr};
              end
            end
            if (q_head.last) begin
              job_nxt   = JOB_F;
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        case (job_r)
          JOB_F: begin
            if (front_min_r[16]) begin
              front_lim_nxt = slim_pkg::FULL_SCALE;
              job_nxt       = JOB_B;
            end else begin
              prod_nxt  = {14'd0, front_min_r[15:0]} *
                          slim_pkg::DIVD_W'(slim_pkg::CLR_TO_SPEED);
              state_nxt = ST_DIV;
            end
          end
          JOB_B: begin
            if (back_min_r[16]) begin
              back_lim_nxt  = slim_pkg::FULL_SCALE;
              front_min_nxt = slim_pkg::NONE_CLR;
              back_min_nxt  = slim_pkg::NONE_CLR;
              state_nxt     = ST_IDLE;
            end else begin
              prod_nxt  = {14'd0, back_min_r[15:0]} *
                          slim_pkg::DIVD_W'(slim_pkg::CLR_TO_SPEED);
              state_nxt = ST_DIV;
            end
          end
          default: begin
            prod_nxt  = {14'd0, abs_ang_r} * {15'd0, lim_r};
            state_nxt = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          case (job_r)
            JOB_F: begin
              front_lim_nxt = sat_q;
              job_nxt       = JOB_B;
              state_nxt     = ST_MUL;
            end
            JOB_B: begin
              back_lim_nxt  = sat_q;
              front_min_nxt = slim_pkg::NONE_CLR;
              back_min_nxt  = slim_pkg::NONE_CLR;
              state_nxt     = ST_IDLE;
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_lin_nxt     = lin_neg_r ? (~{1'b0, lim_r} + 16'd1) : {1'b0, lim_r};
              out_ang_nxt     = ang_neg_r ? (~q16 + 16'd1) : q16;
              out_limited_nxt = 1'b1;
              state_nxt       = ST_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_F;
      front_min_r <= slim_pkg::NONE_CLR;
      back_min_r  <= slim_pkg::NONE_CLR;
      front_lim_r <= slim_pkg::FULL_SCALE;
      back_lim_r  <= slim_pkg::FULL_SCALE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      front_min_r <= front_min_nxt;
      back_min_r  <= back_min_nxt;
      front_lim_r <= front_lim_nxt;
      back_lim_r  <= back_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r        <= prod_nxt;
    mag_r         <= mag_nxt;
    abs_ang_r     <= abs_ang_nxt;
    lim_r         <= lim_nxt;
    lin_neg_r     <= lin_neg_nxt;
    ang_neg_r     <= ang_neg_nxt;
    out_lin_r     <= out_lin_nxt;
    out_ang_r     <= out_ang_nxt;
    out_limited_r <= out_limited_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ang_r, out_lin_r};
  assign out_tuser  = out_limited_r;

  `SLIM_ASSERT_NOW(a_cmd_pop_slot, clk, rst_n, pop && q_head.is_cmd,
    !out_valid_r || out_tready, "command popped with output slot busy")
  `SLIM_ASSERT_NOW(a_done_in_wait, clk, rst_n, div_done, state_r == ST_WAIT,
    "divider finished outside wait state")
  `SLIM_ASSERT_NOW(a_cmd_done_free, clk, rst_n,
    div_done && (state_r == ST_WAIT) && (job_r == JOB_CMD), !out_valid_r,
    "limited command result would overwrite a pending beat")
  `SLIM_ASSERT_NEXT(a_commit_clears, clk, rst_n,
    div_done && (state_r == ST_WAIT) && (job_r == JOB_B),
    (front_min_r == slim_pkg::NONE_CLR) && (back_min_r == slim_pkg::NONE_CLR),
    "minimum clearances not cleared after commit")

endmodule
